// ===== design/sfcc_pkg.sv =====
// Shared types, constants and field layout for the stack frame chain checker.
`default_nettype none

package sfcc_pkg;

   // Parameter defaults
   localparam int DEFAULT_ADDR_WIDTH        = 32;
   localparam int DEFAULT_FRAME_COUNT_WIDTH = 8;

   // Field widths
   localparam int WORD_W     = 32;
   localparam int ID_W       = 8;
   localparam int DESC_W     = 64;
   localparam int NUMBER_W   = 8;
   localparam int TOTAL_W    = 9;
   localparam int LIMIT_W    = 33;
   localparam int VERDICT_W  = 3;
   localparam int CSR_INDEX_W = 3;

   // Request tdata layout, lowest bit first
   localparam int REQ_ID_LO     = 0;
   localparam int REQ_BUSY_LO   = REQ_ID_LO + ID_W;
   localparam int REQ_EIP_LO    = REQ_BUSY_LO + 1;
   localparam int REQ_EBP_LO    = REQ_EIP_LO + WORD_W;
   localparam int REQ_ESP_LO    = REQ_EBP_LO + WORD_W;
   localparam int REQ_DESC_LO   = REQ_ESP_LO + WORD_W;
   localparam int REQ_SLOW_LO   = REQ_DESC_LO + DESC_W;
   localparam int REQ_SHIGH_LO  = REQ_SLOW_LO + WORD_W;
   localparam int REQ_LINK_LO   = REQ_SHIGH_LO + WORD_W;
   localparam int REQ_RET_LO    = REQ_LINK_LO + WORD_W;
   localparam int REQ_USED_W    = REQ_RET_LO + WORD_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int RSP_FETCH_LO  = 0;
   localparam int RSP_NUMBER_LO = RSP_FETCH_LO + WORD_W;
   localparam int RSP_LOW_LO    = RSP_NUMBER_LO + NUMBER_W;
   localparam int RSP_USED_W    = RSP_LOW_LO + WORD_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic {
      CMD_BEGIN = 1'b0,
      CMD_FRAME = 1'b1
   } command_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NEED   = 3'd0,
      VERDICT_SKIP   = 3'd1,
      VERDICT_EIP    = 3'd2,
      VERDICT_BADRET = 3'd3,
      VERDICT_CLEAN  = 3'd4,
      VERDICT_LIMIT  = 3'd5
   } verdict_type;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NATIVE_COUNT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_TOTAL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_STACK_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TASK_STACK_SIZE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LIMIT     = 3'd5;

   // Register reset values
   localparam logic [ID_W-1:0]     TASK_COUNT_RESET      = 8'd4;
   localparam logic [ID_W-1:0]     NATIVE_COUNT_RESET    = 8'd3;
   localparam logic [TOTAL_W-1:0]  PROCESS_TOTAL_RESET   = 9'd32;
   localparam logic [WORD_W-1:0]   TASK_STACK_BASE_RESET = 32'd0;
   localparam logic [WORD_W-1:0]   TASK_STACK_SIZE_RESET = 32'd65536;
   localparam logic [NUMBER_W-1:0] FRAME_LIMIT_RESET     = 8'd32;

   // Descriptor decode
   localparam int GRAN_SHIFT = 12;

endpackage

`default_nettype wire

// ===== design/stack_frame_chain_checker.sv =====
// Stack frame chain checker: descriptor decode, process classification and frame walk.
//
// A begin transfer (tuser = 0) presents one process; the block answers with a skip, an
// eip-in-stack flag, a clean end, a limit verdict, or a request for the first frame at
// its linear address. Each frame transfer (tuser = 1) carries the link and return words
// read at the requested address and is answered by the next request or a final verdict;
// a frame transfer while no walk is open is dropped without a response. A begin abandons
// any open walk. The block takes one transfer per cycle, sustained, while the response
// side is not stalled: a request is held in the input register and its response is
// loaded into the output register; a held response with rsp_tready low stalls both.
// The check itself is a handful of compares and two address adds, combinational between
// the two registers, with the walk state updated as the output register loads, so
// back-to-back frames see it. No clearing pass is needed after reset.
`default_nettype none

module stack_frame_chain_checker
   import sfcc_pkg::*;
#(
   parameter int ADDR_WIDTH        = DEFAULT_ADDR_WIDTH,
   parameter int FRAME_COUNT_WIDTH = DEFAULT_FRAME_COUNT_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // proc_id, proc_busy, instr_pointer, frame_pointer, stack_pointer, seg_descriptor,
   // stack_low_in, stack_high_in, frame_link, frame_return, zero fill
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   req_tuser,   // command
   // response stream
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // fetch_address, frame_number, stack_low_out
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   output      logic [VERDICT_W-1:0]   rsp_tuser,   // verdict
   // register writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_data
);

   localparam int FCW   = FRAME_COUNT_WIDTH;
   localparam int CMP_W = (FCW > NUMBER_W) ? FCW : NUMBER_W;

   // Configuration registers
   logic [ID_W-1:0]     task_count_ff;
   logic [ID_W-1:0]     native_count_ff;
   logic [TOTAL_W-1:0]  process_total_ff;
   logic [WORD_W-1:0]   task_base_ff;
   logic [WORD_W-1:0]   task_size_ff;
   logic [NUMBER_W-1:0] frame_limit_ff;

   // Input register
   logic                  req_valid_ff, req_valid_in;
   logic [REQ_USED_W-1:0] req_data_ff;
   logic                  req_user_ff;

   // Walk state
   logic               walking_ff, walking_in;
   logic               user_mode_ff, user_mode_in;
   logic [WORD_W-1:0]  segment_base_ff, segment_base_in;
   logic [LIMIT_W-1:0] segment_limit_ff, segment_limit_in;
   logic [WORD_W-1:0]  current_frame_ff, current_frame_in;
   logic [WORD_W-1:0]  saved_sp_ff, saved_sp_in;
   logic [FCW-1:0]     frames_done_ff, frames_done_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         rsp_verdict_ff, rsp_verdict_in;
   logic [WORD_W-1:0]   rsp_fetch_ff, rsp_fetch_in;
   logic [NUMBER_W-1:0] rsp_number_ff, rsp_number_in;
   logic [WORD_W-1:0]   rsp_low_ff, rsp_low_in;

   logic advance, req_accept, emit, load;
   command_type command;

   // Decoded request fields
   logic [ID_W-1:0]   proc_id;
   logic              proc_busy;
   logic [WORD_W-1:0] eip, ebp, esp, stack_low_rec, stack_high_rec, link, ret;
   logic [DESC_W-1:0] desc;

   // Begin-side terms
   logic [19:0]          raw_limit;
   logic [20:0]          raw_plus;
   logic [TOTAL_W-1:0]   class_sum;
   logic                 begin_user;
   logic [WORD_W-1:0]    begin_base, low_mark;
   logic [ADDR_WIDTH-1:0] begin_sum, walk_sum;

   // Frame-side terms
   logic              ret_ok;
   logic [WORD_W-1:0] ret_offset;
   logic [FCW-1:0]    frames_next;

   assign csr_ready  = 1'b1;
   assign command    = command_type'(req_user_ff);
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign load       = advance && emit;

   assign proc_id        = req_data_ff[REQ_ID_LO +: ID_W];
   assign proc_busy      = req_data_ff[REQ_BUSY_LO];
   assign eip            = req_data_ff[REQ_EIP_LO +: WORD_W];
   assign ebp            = req_data_ff[REQ_EBP_LO +: WORD_W];
   assign esp            = req_data_ff[REQ_ESP_LO +: WORD_W];
   assign desc           = req_data_ff[REQ_DESC_LO +: DESC_W];
   assign stack_low_rec  = req_data_ff[REQ_SLOW_LO +: WORD_W];
   assign stack_high_rec = req_data_ff[REQ_SHIGH_LO +: WORD_W];
   assign link           = req_data_ff[REQ_LINK_LO +: WORD_W];
   assign ret            = req_data_ff[REQ_RET_LO +: WORD_W];

   // Descriptor base and limit; the granularity bit scales the limit to 4K pages
   assign begin_base = {desc[63:56], desc[39:32], desc[31:16]};
   assign raw_limit  = {desc[51:48], desc[15:0]};
   assign raw_plus   = {1'b0, raw_limit} + 21'd1;

   assign class_sum  = {1'b0, task_count_ff} + {1'b0, native_count_ff};
   assign begin_user = !(({1'b0, proc_id} < {1'b0, task_count_ff}) ||
                         ({1'b0, proc_id} < class_sum));
   assign low_mark   = (begin_user && (esp < stack_low_rec)) ? esp : stack_low_rec;

   // Linear frame address, wrapping at the address width
   assign begin_sum = ADDR_WIDTH'(begin_base) + ADDR_WIDTH'(ebp);
   assign walk_sum  = ADDR_WIDTH'(segment_base_ff) + ADDR_WIDTH'(link);

   assign ret_offset  = ret - task_base_ff;
   assign frames_next = FCW'(frames_done_ff + 1'b1);

   always_comb begin
      if (user_mode_ff) begin
         ret_ok = ({1'b0, ret} < segment_limit_ff) && (ret < saved_sp_ff);
      end else begin
         ret_ok = !((ret >= task_base_ff) && (ret_offset < task_size_ff));
      end
   end

   always_comb begin
      emit             = 1'b1;
      rsp_verdict_in   = VERDICT_NEED;
      rsp_fetch_in     = '0;
      rsp_number_in    = '0;
      rsp_low_in       = '0;
      walking_in       = walking_ff;
      user_mode_in     = user_mode_ff;
      segment_base_in  = segment_base_ff;
      segment_limit_in = segment_limit_ff;
      current_frame_in = current_frame_ff;
      saved_sp_in      = saved_sp_ff;
      frames_done_in   = frames_done_ff;

      case (command)
         CMD_BEGIN: begin
            walking_in = 1'b0;
            if (({1'b0, proc_id} >= process_total_ff) || proc_busy) begin
               rsp_verdict_in = VERDICT_SKIP;
               rsp_low_in     = stack_low_rec;
            end else begin
               segment_base_in = begin_base;
               if (desc[55]) begin
                  segment_limit_in = {raw_plus, {GRAN_SHIFT{1'b0}}};
               end else begin
                  segment_limit_in = LIMIT_W'(raw_plus);
               end
               user_mode_in = begin_user;
               rsp_low_in   = low_mark;
               if (begin_user && (eip >= low_mark) && (eip < stack_high_rec)) begin
                  rsp_verdict_in = VERDICT_EIP;
               end else if (ebp == '0) begin
                  rsp_verdict_in = VERDICT_CLEAN;
               end else if (frame_limit_ff == '0) begin
                  rsp_verdict_in = VERDICT_LIMIT;
               end else begin
                  current_frame_in = ebp;
                  saved_sp_in      = esp;
                  frames_done_in   = '0;
                  walking_in       = 1'b1;
                  rsp_fetch_in     = begin_user ? WORD_W'(begin_sum) : WORD_W'(ADDR_WIDTH'(ebp));
               end
            end
         end
         CMD_FRAME: begin
            if (!walking_ff) begin
               // stray frame: drop
               emit = 1'b0;
            end else if (link == '0) begin
               walking_in     = 1'b0;
               rsp_verdict_in = VERDICT_CLEAN;
               rsp_number_in  = NUMBER_W'(frames_done_ff);
            end else if (!ret_ok || (link <= current_frame_ff)) begin
               walking_in     = 1'b0;
               rsp_verdict_in = VERDICT_BADRET;
               rsp_number_in  = NUMBER_W'(frames_done_ff);
            end else begin
               current_frame_in = link;
               frames_done_in   = frames_next;
               if (CMP_W'(frames_next) >= CMP_W'(frame_limit_ff)) begin
                  walking_in     = 1'b0;
                  rsp_verdict_in = VERDICT_LIMIT;
                  rsp_number_in  = frame_limit_ff;
               end else begin
                  rsp_number_in = NUMBER_W'(frames_next);
                  rsp_fetch_in  = user_mode_ff ? WORD_W'(walk_sum)
                                               : WORD_W'(ADDR_WIDTH'(link));
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         walking_ff       <= 1'b0;
         task_count_ff    <= TASK_COUNT_RESET;
         native_count_ff  <= NATIVE_COUNT_RESET;
         process_total_ff <= PROCESS_TOTAL_RESET;
         task_base_ff     <= TASK_STACK_BASE_RESET;
         task_size_ff     <= TASK_STACK_SIZE_RESET;
         frame_limit_ff   <= FRAME_LIMIT_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            walking_ff <= walking_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TASK_COUNT:      task_count_ff    <= csr_data[ID_W-1:0];
               CSR_NATIVE_COUNT:    native_count_ff  <= csr_data[ID_W-1:0];
               CSR_PROCESS_TOTAL:   process_total_ff <= csr_data[TOTAL_W-1:0];
               CSR_TASK_STACK_BASE: task_base_ff     <= csr_data;
               CSR_TASK_STACK_SIZE: task_size_ff     <= csr_data;
               CSR_FRAME_LIMIT:     frame_limit_ff   <= csr_data[NUMBER_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload and walk context
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_data_ff <= req_tdata[REQ_USED_W-1:0];
         req_user_ff <= req_tuser;
      end
      if (advance) begin
         user_mode_ff     <= user_mode_in;
         segment_base_ff  <= segment_base_in;
         segment_limit_ff <= segment_limit_in;
         current_frame_ff <= current_frame_in;
         saved_sp_ff      <= saved_sp_in;
         frames_done_ff   <= frames_done_in;
      end
      if (load) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_fetch_ff   <= rsp_fetch_in;
         rsp_number_ff  <= rsp_number_in;
         rsp_low_ff     <= rsp_low_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_verdict_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_low_ff, rsp_number_ff, rsp_fetch_ff});

   // A stray frame leaves the response side untouched
   assert property (@(posedge clock) disable iff (reset)
      (advance && (command == CMD_FRAME) && !walking_ff)
         |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready)))
      else $error("stray frame produced a response");

   // The walk stays open exactly when the last response asked for a frame
   assert property (@(posedge clock) disable iff (reset)
      load |=> (walking_ff == (rsp_verdict_ff == VERDICT_NEED)))
      else $error("walk state disagrees with verdict");

   // Only a frame request carries an address
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_verdict_ff != VERDICT_NEED)) |-> (rsp_fetch_ff == '0))
      else $error("address on a final verdict");

   // A frame-side response never carries a low-water mark
   assert property (@(posedge clock) disable iff (reset)
      (load && (command == CMD_FRAME)) |=> (rsp_low_ff == '0))
      else $error("low-water mark on a frame response");

endmodule

`default_nettype wire
